// ----- sv/kse_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kse_pkg: shared types and constants for the key scan decoder
// Field widths, knob direction codes, per-lane status and the note table.
// ----------------------------------------------------------------------------
package kse_pkg;

  localparam int KNOB_W     = 2;
  localparam int NOTE_W     = 4;
  localparam int STEP_W     = 32;
  localparam int VOL_W      = 4;
  localparam int TABLE_SIZE = 12;

  // knob direction codes
  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_UP   = 2'd1;
  localparam logic [1:0] DIR_DOWN = 2'd2;

  // status of one key lane towards the merge stage
  typedef struct packed {
    logic              req;
    logic              pressed;
    logic [STEP_W-1:0] step;
  } lane_t;

  // phase increment of a note, zero for keys beyond the table
  function automatic logic [STEP_W-1:0] note_step(input int unsigned idx);
    logic [STEP_W-1:0] val;
    case (idx)
      0:       val = 32'd51076057;
      1:       val = 32'd54113197;
      2:       val = 32'd57330935;
      3:       val = 32'd60740010;
      4:       val = 32'd64351799;
      5:       val = 32'd68178356;
      6:       val = 32'd72232452;
      7:       val = 32'd76527617;
      8:       val = 32'd81078186;
      9:       val = 32'd85899346;
      10:      val = 32'd91007187;
      11:      val = 32'd96418756;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

// ----- sv/kse_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kse_in_if / kse_out_if: scan and result channels
// Valid/ready channels carrying one scan beat in and one result beat out.
// ----------------------------------------------------------------------------
interface kse_in_if #(
  parameter int KeyCount = 12
);
  logic                valid;
  logic                ready;
  logic [KeyCount-1:0] key_levels;
  logic [1:0]          knob_bits;

  modport source (output valid, output key_levels, output knob_bits, input ready);
  modport sink   (input valid, input key_levels, input knob_bits, output ready);
endinterface

interface kse_out_if;
  logic        valid;
  logic        ready;
  logic        is_event;
  logic        key_pressed;
  logic [3:0]  note_index;
  logic [31:0] phase_step;
  logic [3:0]  volume_level;
  logic        last_of_run;

  modport source (output valid, output is_event, output key_pressed, output note_index,
                  output phase_step, output volume_level, output last_of_run,
                  input ready);
  modport sink   (input valid, input is_event, input key_pressed, input note_index,
                  input phase_step, input volume_level, input last_of_run,
                  output ready);
endinterface

// ----- sv/kse_lane.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kse_lane: change detector for one key
// Holds the key's previous level, flags a change on each scan and offers
// the press flag and phase increment until the merge stage grants it.
// ----------------------------------------------------------------------------
module kse_lane import kse_pkg::*; #(
  parameter int Index = 0
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  load_i,
  input  logic  level_i,
  input  logic  grant_i,
  output lane_t lane_o
);

  localparam logic [STEP_W-1:0] NoteStep = note_step(Index);

  logic level_q, level_d;
  logic pending_q, pending_d;

  // previous level and pending change
  always_comb begin
    level_d   = level_q;
    pending_d = pending_q;
    if (load_i) begin
      level_d   = level_i;
      pending_d = level_i ^ level_q;
    end else if (grant_i) begin
      pending_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q   <= 1'b0;
      pending_q <= 1'b0;
    end else begin
      level_q   <= level_d;
      pending_q <= pending_d;
    end
  end

  // active-low level: a low key is pressed
  assign lane_o.req     = pending_q;
  assign lane_o.pressed = ~level_q;
  assign lane_o.step    = level_q ? '0 : NoteStep;

endmodule

// ----- sv/kse_knob.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kse_knob: half-step quadrature decoder
// Counts knob steps per scan, repeats the last direction on a both-bits
// jump and saturates the level to 0..VolumeMax.
// ----------------------------------------------------------------------------
module kse_knob import kse_pkg::*; #(
  parameter int VolumeMax = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  logic [KNOB_W-1:0] knob_i,
  output logic [VOL_W-1:0]  volume_o
);

  localparam logic [VOL_W-1:0] VolMax = VOL_W'(VolumeMax);

  // old/new AB transition codes
  localparam logic [3:0] TR_UP_A   = 4'b0001;
  localparam logic [3:0] TR_UP_B   = 4'b1110;
  localparam logic [3:0] TR_DN_A   = 4'b0100;
  localparam logic [3:0] TR_DN_B   = 4'b1011;
  localparam logic [3:0] TR_JUMP_A = 4'b0011;
  localparam logic [3:0] TR_JUMP_B = 4'b0110;
  localparam logic [3:0] TR_JUMP_C = 4'b1001;
  localparam logic [3:0] TR_JUMP_D = 4'b1100;

  logic [KNOB_W-1:0] prev_q, prev_d;
  logic [VOL_W-1:0]  count_q, count_d;
  logic [1:0]        dir_q, dir_d;
  logic              step_up, step_dn;

  // decode the transition
  always_comb begin
    step_up = 1'b0;
    step_dn = 1'b0;
    dir_d   = dir_q;
    case ({prev_q, knob_i})
      TR_UP_A, TR_UP_B: begin
        step_up = 1'b1;
        dir_d   = DIR_UP;
      end
      TR_DN_A, TR_DN_B: begin
        step_dn = 1'b1;
        dir_d   = DIR_DOWN;
      end
      TR_JUMP_A, TR_JUMP_B, TR_JUMP_C, TR_JUMP_D: begin
        step_up = (dir_q == DIR_UP);
        step_dn = (dir_q == DIR_DOWN);
      end
      default: begin
      end
    endcase
  end

  // saturating count
  always_comb begin
    count_d = count_q;
    if (step_up && count_q < VolMax) begin
      count_d = count_q + 1'b1;
    end else if (step_dn && count_q != '0) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= '0;
      count_q <= '0;
      dir_q   <= DIR_NONE;
    end else if (load_i) begin
      prev_q  <= knob_i;
      count_q <= count_d;
      dir_q   <= dir_d;
    end
  end

  assign volume_o = count_q;

endmodule

// ----- sv/kse_merge.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kse_merge: event sequencer and output register
// Grants the lowest pending lane each cycle the output register can take a beat,
// tracks the running phase step and closes every scan with a summary beat.
// ----------------------------------------------------------------------------
module kse_merge import kse_pkg::*; #(
  parameter int KeyCount = 12
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  lane_t            lanes_i [KeyCount],
  input  logic [VOL_W-1:0] volume_i,
  output logic [KeyCount-1:0] grant_o,
  output logic             busy_o,
  kse_out_if.source        out_o
);

  logic [KeyCount-1:0] req;
  logic [KeyCount-1:0] lowest;
  logic                any_req;
  logic                out_free;
  logic                emit;
  logic                sel_pressed;
  logic [NOTE_W-1:0]   sel_note;
  logic [STEP_W-1:0]   sel_step;

  logic                busy_q, busy_d;
  logic [STEP_W-1:0]   cur_step_q, cur_step_d;
  logic                out_valid_q, out_valid_d;
  logic                is_event_q, pressed_q, last_q;
  logic [NOTE_W-1:0]   note_q;
  logic [STEP_W-1:0]   step_q;
  logic [VOL_W-1:0]    vol_q;

  // lowest pending lane and its payload
  always_comb begin
    for (int i = 0; i < KeyCount; i++) begin
      req[i] = lanes_i[i].req;
    end
    lowest      = req & (~req + KeyCount'(1));
    any_req     = |req;
    sel_pressed = 1'b0;
    sel_note    = '0;
    sel_step    = '0;
    for (int i = 0; i < KeyCount; i++) begin
      if (lowest[i]) begin
        sel_pressed = sel_pressed | lanes_i[i].pressed;
        sel_note    = sel_note | NOTE_W'(i);
        sel_step    = sel_step | lanes_i[i].step;
      end
    end
  end

  assign out_free = !out_valid_q || out_o.ready;
  assign emit     = busy_q && out_free;
  assign grant_o  = emit ? lowest : '0;

  // sequencer state
  always_comb begin
    busy_d      = busy_q;
    cur_step_d  = cur_step_q;
    out_valid_d = out_valid_q;
    if (start_i) begin
      busy_d = 1'b1;
    end else if (emit && !any_req) begin
      busy_d = 1'b0;
    end
    if (emit && any_req) begin
      cur_step_d = sel_step;
    end
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      cur_step_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      cur_step_q  <= cur_step_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result beat register
  always_ff @(posedge clk_i) begin
    if (emit) begin
      is_event_q <= any_req;
      pressed_q  <= any_req & sel_pressed;
      note_q     <= any_req ? sel_note : '0;
      step_q     <= any_req ? sel_step : cur_step_q;
      vol_q      <= volume_i;
      last_q     <= !any_req;
    end
  end

  assign busy_o             = busy_q;
  assign out_o.valid        = out_valid_q;
  assign out_o.is_event     = is_event_q;
  assign out_o.key_pressed  = pressed_q;
  assign out_o.note_index   = note_q;
  assign out_o.phase_step   = step_q;
  assign out_o.volume_level = vol_q;
  assign out_o.last_of_run  = last_q;

  // at most one lane granted per cycle
  a_grant_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(grant_o)) else $error("more than one lane granted");

  // a new scan only starts when the sequencer is idle
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("scan loaded while busy");

  // the summary beat ends the scan
  a_summary_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && !any_req) |=> (!busy_q && out_valid_q && last_q))
    else $error("summary did not close the scan");

  // no lane is left pending once the scan is closed
  a_idle_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!busy_q && !start_i) |-> !any_req) else $error("pending lane while idle");

endmodule

// ----- sv/key_scan_event_and_knob_decoder_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_scan_event_and_knob_decoder_top: key change events and knob level
// Per-key lanes detect changes against the previous scan, the merge stage
// emits one event beat per changed key in key order, then a summary beat.
// ----------------------------------------------------------------------------
// flow: a taken scan is registered into the lanes and the sequencer, then
//   each beat into the output register; a scan with n changed keys yields
//   n+1 beats and the next scan is taken once its summary is registered,
//   one beat per cycle from the merge while the output register is free
// reset: asynchronous, clears previous key levels (all pressed), knob state
//   and running phase step; no clearing pass
module key_scan_event_and_knob_decoder_top import kse_pkg::*; #(
  parameter int KEY_COUNT  = 12,
  parameter int VOLUME_MAX = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  kse_in_if.sink    in_i,
  kse_out_if.source out_o
);

  lane_t                lanes [KEY_COUNT];
  logic [KEY_COUNT-1:0] grant;
  logic                 busy;
  logic                 accept;
  logic [VOL_W-1:0]     volume;

  // one scan at a time
  assign in_i.ready = !busy;
  assign accept     = in_i.valid && !busy;

  // key lanes
  for (genvar i = 0; i < KEY_COUNT; i++) begin : g_lane
    kse_lane #(
      .Index (i)
    ) u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .load_i  (accept),
      .level_i (in_i.key_levels[i]),
      .grant_i (grant[i]),
      .lane_o  (lanes[i])
    );
  end

  // knob decoder
  kse_knob #(
    .VolumeMax (VOLUME_MAX)
  ) u_knob (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (accept),
    .knob_i   (in_i.knob_bits),
    .volume_o (volume)
  );

  // event sequencer
  kse_merge #(
    .KeyCount (KEY_COUNT)
  ) u_merge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (accept),
    .lanes_i  (lanes),
    .volume_i (volume),
    .grant_o  (grant),
    .busy_o   (busy),
    .out_o    (out_o)
  );

endmodule
